[rtl/sidac_pkg.sv]
// shared types and constants for the signed integer to decimal ascii converter
package sidac_pkg;

  // stream widths
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 16;
  localparam int CHAR_W      = 6;
  localparam int COUNT_OUT_W = 4;

  // converted value width, bit VALUE_BITS-1 is the sign
  localparam int VALUE_BITS  = 32;

  // decimal digits needed for the largest magnitude 2^(VALUE_BITS-1)
  localparam int NUM_DIGITS  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W       = NUM_DIGITS * 4;
  localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int CONV_W      = $clog2(VALUE_BITS);
  localparam int COUNT_W     = 5;

  // queue between front and back, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

  // classified item: sign and magnitude
  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

endpackage

[rtl/sidac_front.sv]
// front stage: accepts values and splits them into sign and magnitude
module sidac_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sidac_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                           item_valid,
  input  logic                           item_ready,
  output sidac_pkg::item_t               item
);
  import sidac_pkg::*;

  logic                  held;
  item_t                 item_reg;
  logic [VALUE_BITS-1:0] v;
  item_t                 item_next;

  assign s_tready = !held || item_ready;

  always_comb begin
    v             = s_tdata[VALUE_BITS-1:0];
    item_next.neg = v[VALUE_BITS-1];
    // two's complement negate, most negative value wraps to 2^(VALUE_BITS-1)
    item_next.mag = item_next.neg ? (~v + VALUE_BITS'(1)) : v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_reg <= item_next;
    end
  end

  assign item_valid = held;
  assign item       = item_reg;

endmodule

[rtl/sidac_queue.sv]
// short fifo between the classifying front and the converting back
module sidac_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sidac_pkg::item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sidac_pkg::item_t out_item
);
  import sidac_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

[rtl/sidac_back.sv]
// back stage: shift-add-3 conversion, leading digit search and character output
module sidac_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sidac_pkg::item_t                 in_item,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sidac_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import sidac_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LEAD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state;
  logic [CONV_W-1:0]      cnt;
  logic [VALUE_BITS-1:0]  sh;
  logic [BCD_W-1:0]       bcd;
  logic                   neg;
  logic                   pend_minus;
  logic [DIG_IDX_W-1:0]   idx;
  logic [COUNT_W-1:0]     total;
  logic                   m_valid;
  logic [CHAR_W-1:0]      m_char;
  logic                   m_last;
  logic [COUNT_OUT_W-1:0] m_count;

  logic [BCD_W-1:0]       bcd_adj;
  logic [BCD_W-1:0]       bcd_next;
  logic [DIG_IDX_W-1:0]   top;
  logic [3:0]             cur_digit;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !m_valid || m_tready;

  // one double-dabble step: add 3 to digits of 5 or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
    bcd_next = {bcd_adj[BCD_W-2:0], sh[VALUE_BITS-1]};
  end

  // highest nonzero digit, zero keeps a single digit
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        top = DIG_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[idx*4 +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (cnt == '0) begin
            state <= ST_LEAD;
          end
        end
        ST_LEAD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_valid <= 1'b1;
            if (!pend_minus && idx == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sh  <= in_item.mag;
        neg <= in_item.neg;
        bcd <= '0;
        cnt <= CONV_W'(VALUE_BITS - 1);
      end
      ST_CONV: begin
        bcd <= bcd_next;
        sh  <= {sh[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt - CONV_W'(1);
      end
      ST_LEAD: begin
        idx        <= top;
        total      <= COUNT_W'(top) + COUNT_W'(1) + COUNT_W'(neg);
        pend_minus <= neg;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (pend_minus) begin
            m_char     <= CHAR_MINUS;
            m_last     <= 1'b0;
            m_count    <= '0;
            pend_minus <= 1'b0;
          end else begin
            m_char  <= CHAR_ZERO + CHAR_W'(cur_digit);
            m_last  <= (idx == '0);
            m_count <= (idx == '0) ? total[COUNT_OUT_W-1:0] : '0;
            if (idx != '0) begin
              idx <= idx - DIG_IDX_W'(1);
            end
          end
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign m_tvalid = m_valid;
  assign m_tlast  = m_last;
  assign m_tdata  = {(OUT_DATA_W - CHAR_W - COUNT_OUT_W)'(0), m_count, m_char};

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// top level of the signed integer to decimal ascii converter
//
// usage:
//   slave channel s_*: one transfer carries one signed 32-bit value in s_tdata
//   master channel m_*: one transfer per output character; the run for a value
//     is an optional '-' then the decimal digits, most significant first, no
//     leading zeros (zero gives a single '0'); m_tlast marks the final
//     character, which also carries the run length in the count field
// path: from an accepted value to its first valid character the value passes the
//   queue write, converter load, 32 shift-add-3 steps, leading digit search and
//   output register; then one character per cycle while m_tready stays high
// flow: the serial bcd converter takes one value at a time and loads the next
//   only after the last character of the current run has been issued; the
//   front and its two-entry queue take new values while the back still works
// reset: rst clears the queue, the converter state and the output register;
//   no transfer is in flight afterwards
// stall: when m_tready is low the current character holds in the output
//   register and the converter waits; the front keeps taking values until the
//   queue and its own register are full, then drops s_tready
module signed_int_to_decimal_ascii (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sidac_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] value
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sidac_pkg::OUT_DATA_W-1:0] m_tdata,   // [5:0] ascii_char, [9:6] char_count
  output logic                             m_tlast    // last_char
);
  import sidac_pkg::*;

  // front to queue
  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;

  // queue to back
  logic  qb_valid;
  logic  qb_ready;
  item_t qb_item;

  // sign and magnitude split
  sidac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item_valid (fq_valid),
    .item_ready (fq_ready),
    .item       (fq_item)
  );

  // decouples intake from the long conversion
  sidac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  // bcd conversion and character output
  sidac_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (qb_valid),
    .in_ready (qb_ready),
    .in_item  (qb_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[verif/decimal_text_checker.sv]
// watches both stream channels, predicts the decimal text of each value and compares it
module decimal_text_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sidac_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sidac_pkg::OUT_DATA_W-1:0] m_tdata,   // [5:0] ascii_char, [9:6] char_count
  input  logic                             m_tlast,   // last_char
  output int                               fail_count,
  output int                               pending_chars,
  output int                               values_seen,
  output int                               chars_seen
);
  import sidac_pkg::*;

  localparam int DECIMAL_BASE = 10;
  localparam int MAX_DIGITS   = 20;

  typedef struct {
    logic [CHAR_W-1:0]      code;
    logic                   last;
    logic [COUNT_OUT_W-1:0] count;
  } char_item_t;

  char_item_t expected_chars [$];
  int         mismatches;
  int         values_total;
  int         chars_total;

  initial begin
    fail_count    = 0;
    pending_chars = 0;
    values_seen   = 0;
    chars_seen    = 0;
    mismatches    = 0;
    values_total  = 0;
    chars_total   = 0;
  end

  // sign, then digits most significant first; count only on the final digit
  function automatic void predict_decimal_text(input logic [IN_DATA_W-1:0] word);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [3:0]            digits [MAX_DIGITS];
    int                    nd;
    int                    total;
    char_item_t            c;
    v   = word[VALUE_BITS-1:0];
    neg = v[VALUE_BITS-1];
    mag = neg ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      digits[nd] = 4'(mag % DECIMAL_BASE);
      mag        = mag / DECIMAL_BASE;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    total = nd + (neg ? 1 : 0);
    if (neg) begin
      c.code  = CHAR_MINUS;
      c.last  = 1'b0;
      c.count = '0;
      expected_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code  = CHAR_ZERO + CHAR_W'(digits[i]);
      c.last  = (i == 0);
      c.count = c.last ? COUNT_OUT_W'(total) : '0;
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    char_item_t exp_c;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_decimal_text(s_tdata);
        values_total++;
      end
      if (m_tvalid && m_tready) begin
        chars_total++;
        if (expected_chars.size() == 0) begin
          $display("%0t unexpected character: expected none, actual char %0d last %0b count %0d",
                   $time, m_tdata[CHAR_W-1:0], m_tlast, m_tdata[CHAR_W +: COUNT_OUT_W]);
          mismatches++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (m_tdata[CHAR_W-1:0] !== exp_c.code) begin
            $display("%0t ascii_char mismatch: expected %0d actual %0d",
                     $time, exp_c.code, m_tdata[CHAR_W-1:0]);
            mismatches++;
          end
          if (m_tlast !== exp_c.last) begin
            $display("%0t last_char mismatch: expected %0b actual %0b",
                     $time, exp_c.last, m_tlast);
            mismatches++;
          end
          if (m_tdata[CHAR_W +: COUNT_OUT_W] !== exp_c.count) begin
            $display("%0t char_count mismatch: expected %0d actual %0d",
                     $time, exp_c.count, m_tdata[CHAR_W +: COUNT_OUT_W]);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_chars <= expected_chars.size();
    values_seen   <= values_total;
    chars_seen    <= chars_total;
  end

endmodule

[verif/signed_int_to_decimal_ascii_test.sv]
// testbench top for the signed integer to decimal ascii converter
module signed_int_to_decimal_ascii_test;
  import sidac_pkg::*;

  // every input starts at a known value, reset held from time zero
  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [5:0] ascii_char, [9:6] char_count
  logic                  m_tlast;         // last_char

  // pacing knobs, percent of cycles spent idle or stalled
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int fail_count;
  int pending_chars;
  int values_seen;
  int chars_seen;

  signed_int_to_decimal_ascii i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  decimal_text_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_chars (pending_chars),
    .values_seen   (values_seen),
    .chars_seen    (chars_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: ready drops at random with the current stall rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // safety net, far beyond the slowest legal run
  initial begin
    #(12 * 600000);
    $display("FAILURE");
    $finish;
  end

  // one value transfer; random idle cycles before it, valid stays high between
  // back-to-back transfers so it never gets two assignments in one step
  task automatic send_value(input logic [IN_DATA_W-1:0] v);
    while (send_idle_pct > $urandom_range(99)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // sender holds off until every predicted character has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
  endtask

  // mix of full-range words, every digit length, decade boundaries and tiny values
  function automatic logic [IN_DATA_W-1:0] random_value();
    logic [IN_DATA_W-1:0] v;
    logic [IN_DATA_W-1:0] decade;
    v = '0;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: begin
        decade = 1;
        repeat ($urandom_range(9)) decade = decade * 10;
        v = decade - 1 + $urandom_range(2);
      end
      default: v = $urandom_range(20);
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  initial begin
    logic [IN_DATA_W-1:0] corner_values [$];
    int                   phase_idle [4];
    int                   phase_stall [4];

    // zero, single digits, decade edges, both extremes, alternating bit patterns
    corner_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                      -32'sd100, 32'd12345, -32'sd12345, 32'd999999999, 32'd1000000000,
                      -32'sd999999999, -32'sd1000000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h80000001, 32'h55555555, 32'hAAAAAAAA};
    phase_idle  = '{0, 63, 0, 18};
    phase_stall = '{0, 0, 63, 18};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed values, no idling on either side
    foreach (corner_values[i]) send_value(corner_values[i]);
    wait_drained();

    // random values over four pacing phases, draining between them
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct <= phase_stall[p];
      repeat (88) send_value(random_value());
      wait_drained();
    end

    // let any stray character show up before the verdict
    repeat (50) @(posedge clk);
    $display("run covered %0d values and %0d characters: directed corners, then random",
             values_seen, chars_seen);
    $display("values under no pacing, sender idle, receiver stall and mixed pacing");
    if (fail_count == 0 && pending_chars == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
